// File: rtl/core/tskf_pkg.sv
// Types and constants shared by the two-source Kalman fusion block.
// No dependencies.
`timescale 1ns / 1ps
package tskf_pkg;
  localparam int DIM_MAX = 3;
  // estimate components in use, 1..DIM_MAX; the rest report zero
  localparam int EST_DIM = 3;
  localparam logic [1:0] CMD_PREDICT = 2'd0;
  localparam logic [1:0] CMD_SRC1    = 2'd1;
  localparam logic [1:0] CMD_SRC2    = 2'd2;
  localparam logic [1:0] REG_Q  = 2'd0;
  localparam logic [1:0] REG_R1 = 2'd1;
  localparam logic [1:0] REG_R2 = 2'd2;
  // datapath select code for the variance pass
  localparam logic [1:0] SEL_VAR = 2'd3;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] meas_0;
    logic signed [31:0] meas_1;
    logic signed [31:0] meas_2;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] est_0;
    logic signed [31:0] est_1;
    logic signed [31:0] est_2;
    logic [31:0]        variance;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // capture request, form p+r
    logic       predict;   // apply p+q
    logic       mul_start; // start product for component sel
    logic       div_start; // start division
    logic       div_step;  // one quotient bit
    logic       commit;    // write result for component sel
    logic [1:0] sel;       // 0..2 estimate, SEL_VAR variance
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic s_zero;
    logic div_done;
  } dp_sts_t;
endpackage

// File: rtl/core/tskf_ctrl.sv
// Sequencer for the fusion block: walks predict or update steps.
// Depends on tskf_pkg.
`timescale 1ns / 1ps
module tskf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [1:0]         in_cmd,
  input  logic               out_busy,
  input  tskf_pkg::dp_sts_t  sts,
  output tskf_pkg::dp_cmd_t  cmd,
  output logic               in_ready,
  output logic               out_push
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_NEXT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic [1:0] cmd_r, cmd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 2'd0;
      cmd_r   <= tskf_pkg::CMD_PREDICT;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE) && !out_busy;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd_nxt   = cmd_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    out_push  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          cmd_nxt   = in_cmd;
          sel_nxt   = 2'd0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (cmd_r == tskf_pkg::CMD_PREDICT) begin
          cmd.predict = 1'b1;
          state_nxt   = S_DONE;
        end else if (cmd_r inside {tskf_pkg::CMD_SRC1, tskf_pkg::CMD_SRC2}) begin
          state_nxt = sts.s_zero ? S_DONE : S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_NEXT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_NEXT: begin
        if (sel_r == tskf_pkg::SEL_VAR) begin
          state_nxt = S_DONE;
        end else if (32'(sel_r) + 1 >= tskf_pkg::EST_DIM) begin
          sel_nxt   = tskf_pkg::SEL_VAR;
          state_nxt = S_MUL;
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        out_push  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: rtl/core/tskf_dp.sv
// Datapath: state registers, one shared multiplier and a restoring divider.
// Depends on tskf_pkg.
`timescale 1ns / 1ps
module tskf_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  tskf_pkg::in_item_t  req,
  input  tskf_pkg::dp_cmd_t   cmd,
  output tskf_pkg::dp_sts_t   sts,
  output tskf_pkg::out_item_t res
);
  logic [31:0] q_r, r1_r, r2_r;
  logic signed [31:0] est_r [tskf_pkg::DIM_MAX];
  logic [31:0] p_r;
  logic signed [31:0] z_r [tskf_pkg::DIM_MAX];
  logic [31:0] rsel_r;
  logic [32:0] s_r;
  logic [63:0] prod_r;
  logic        neg_r;
  logic [65:0] rem_r;   // remainder window
  logic [65:0] num_r;   // numerator shifting out
  logic [64:0] quo_r;
  logic [6:0]  cnt_r;

  // operand selection for the shared multiplier
  logic signed [32:0] d;
  logic [32:0] dmag;
  logic [31:0] mb;
  always_comb begin
    d    = 33'(z_r[cmd.sel]) - 33'(est_r[cmd.sel]);
    dmag = d[32] ? 33'(-d) : d;
    mb   = (cmd.sel == tskf_pkg::SEL_VAR) ? rsel_r : dmag[31:0];
  end

  // |d| < 2^32 always, so dmag[32] is zero
  logic [65:0] rem_sh;
  logic [65:0] rem_sub;
  assign rem_sh  = {rem_r[64:0], num_r[65]};
  assign rem_sub = rem_sh - 66'(s_r);

  logic [64:0] cq;
  logic signed [34:0] nx;
  always_comb begin
    cq = quo_r;
    nx = neg_r ? 35'(est_r[cmd.sel]) - 35'(cq[33:0])
               : 35'(est_r[cmd.sel]) + 35'(cq[33:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= tskf_pkg::ONE_Q16;
      r1_r <= tskf_pkg::ONE_Q16;
      r2_r <= tskf_pkg::ONE_Q16;
      p_r  <= tskf_pkg::ONE_Q16;
      for (int i = 0; i < tskf_pkg::DIM_MAX; i++) est_r[i] <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          tskf_pkg::REG_Q:  q_r  <= cfg_data;
          tskf_pkg::REG_R1: r1_r <= cfg_data;
          tskf_pkg::REG_R2: r2_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        z_r[0] <= req.meas_0;
        z_r[1] <= req.meas_1;
        z_r[2] <= req.meas_2;
        rsel_r <= (req.command == tskf_pkg::CMD_SRC2) ? r2_r : r1_r;
        s_r    <= 33'(p_r) + ((req.command == tskf_pkg::CMD_SRC2) ? 33'(r2_r) : 33'(r1_r));
      end
      if (cmd.predict) begin
        p_r <= (33'(p_r) + 33'(q_r) > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : p_r + q_r;
      end
      if (cmd.mul_start) begin
        prod_r <= 64'(p_r) * 64'(mb);
        neg_r  <= (cmd.sel != tskf_pkg::SEL_VAR) && d[32];
      end
      if (cmd.div_start) begin
        num_r <= 66'(prod_r) + 66'(s_r[32:1]);
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= 7'd66;
      end
      if (cmd.div_step) begin
        num_r <= {num_r[64:0], 1'b0};
        if (!rem_sub[65]) begin
          rem_r <= rem_sub;
          quo_r <= {quo_r[63:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[63:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
      end
      if (cmd.commit) begin
        if (cmd.sel == tskf_pkg::SEL_VAR) begin
          p_r <= cq[31:0];
        end else if (nx > 35'sh7FFF_FFFF) begin
          est_r[cmd.sel] <= 32'sh7FFF_FFFF;
        end else if (nx < -35'sh8000_0000) begin
          est_r[cmd.sel] <= 32'sh8000_0000;
        end else begin
          est_r[cmd.sel] <= nx[31:0];
        end
      end
    end
  end

  assign sts.s_zero   = (s_r == '0);
  assign sts.div_done = (cnt_r == '0);

  always_comb begin
    res.est_0    = est_r[0];
    res.est_1    = (tskf_pkg::EST_DIM > 1) ? est_r[1] : '0;
    res.est_2    = (tskf_pkg::EST_DIM > 2) ? est_r[2] : '0;
    res.variance = p_r;
  end
endmodule

// File: rtl/core/two_source_kalman_fusion.sv
// Top level of the two-source Kalman fusion block: controller, datapath, output register.
// Depends on tskf_pkg, tskf_ctrl, tskf_dp.
//
//  channel | ports                      | payload
//  in      | in_valid / in_ready        | in_data (tskf_pkg::in_item_t)
//  out     | out_valid / out_ready      | out_data (tskf_pkg::out_item_t)
//  cfg     | cfg_we, cfg_idx            | cfg_data (32 bit)
//
// Predict, unused command or p+r of zero skip the divider. Each update runs the shared
// 66-step restoring divider per estimate and for variance, one quotient bit per cycle.
// Synchronous active-low reset restores registers, variance 1.0, estimate 0.
// The result sits in an output register; the next request is taken once that
// register is free or being drained.
`timescale 1ns / 1ps
module two_source_kalman_fusion (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tskf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tskf_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [31:0]         cfg_data
);
  tskf_pkg::dp_cmd_t   cmd;
  tskf_pkg::dp_sts_t   sts;
  tskf_pkg::out_item_t res;
  logic in_fire, out_push, out_busy;

  assign in_fire  = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;

  tskf_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_cmd(in_data.command), .out_busy,
    .sts, .cmd, .in_ready, .out_push
  );

  tskf_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .req(in_data),
    .cmd, .sts, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) out_data <= res;
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_valid || out_ready) else $error("result overwrite");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(out_valid && !out_ready)) else $error("accept while output stalled");
  a_push_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !out_push) else $error("result too early");
endmodule

// File: verif/two_source_kalman_fusion_test.sv
// Testbench for two_source_kalman_fusion: random and directed predict/update requests,
// results checked against a scalar-variance Kalman predictor in a scoreboard class.
// Depends on tskf_pkg and the two_source_kalman_fusion RTL.
`timescale 1ns / 1ps
module two_source_kalman_fusion_test;
  localparam int CMD_UNUSED = 3;
  localparam int REG_BAD = 3;
  localparam longint CYCLE_LIMIT = 2000000;

  class fusion_scoreboard;
    logic [31:0] q_noise, r_one, r_two;
    logic signed [31:0] est [tskf_pkg::DIM_MAX];
    logic [31:0] var_p;
    tskf_pkg::out_item_t pending [$];
    int errors;

    function void clear();
      q_noise = tskf_pkg::ONE_Q16; r_one = tskf_pkg::ONE_Q16; r_two = tskf_pkg::ONE_Q16;
      for (int i = 0; i < tskf_pkg::DIM_MAX; i++) est[i] = 0;
      var_p = tskf_pkg::ONE_Q16;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == tskf_pkg::REG_Q) q_noise = val;
      else if (idx == tskf_pkg::REG_R1) r_one = val;
      else if (idx == tskf_pkg::REG_R2) r_two = val;
    endfunction

    // round(a*b/s) half away from zero on magnitudes; product fits 64 bits
    function logic [63:0] scaled_ratio(logic [63:0] a, logic [63:0] b, logic [63:0] s);
      logic [127:0] prod;
      prod = a * b;
      return 64'((prod + 128'(s >> 1)) / s);
    endfunction

    function void note_request(tskf_pkg::in_item_t req);
      logic [63:0] s, mag, corr, np;
      logic [31:0] r;
      logic signed [63:0] x, z, d, nx;
      logic signed [31:0] meas [tskf_pkg::DIM_MAX];
      tskf_pkg::out_item_t res;
      meas[0] = req.meas_0; meas[1] = req.meas_1; meas[2] = req.meas_2;
      if (req.command == tskf_pkg::CMD_PREDICT) begin
        np = 64'(var_p) + 64'(q_noise);
        var_p = (np > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : np[31:0];
      end else if (req.command == tskf_pkg::CMD_SRC1 ||
                   req.command == tskf_pkg::CMD_SRC2) begin
        r = (req.command == tskf_pkg::CMD_SRC1) ? r_one : r_two;
        s = 64'(var_p) + 64'(r);
        if (s != 0) begin
          for (int i = 0; i < tskf_pkg::EST_DIM; i++) begin
            x = est[i];
            z = meas[i];
            d = z - x;
            mag = (d < 0) ? 64'(-d) : 64'(d);
            corr = scaled_ratio(64'(var_p), mag, s);
            nx = (d < 0) ? x - $signed(corr) : x + $signed(corr);
            if (nx > 64'sd2147483647) nx = 64'sd2147483647;
            if (nx < -64'sd2147483648) nx = -64'sd2147483648;
            est[i] = nx[31:0];
          end
          var_p = 32'(scaled_ratio(64'(var_p), 64'(r), s));
        end
      end
      res.est_0 = est[0];
      res.est_1 = (tskf_pkg::EST_DIM > 1) ? est[1] : '0;
      res.est_2 = (tskf_pkg::EST_DIM > 2) ? est[2] : '0;
      res.variance = var_p;
      pending.push_back(res);
    endfunction

    function void check_result(tskf_pkg::out_item_t got);
      tskf_pkg::out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.est_0 !== want.est_0 || got.est_1 !== want.est_1 ||
          got.est_2 !== want.est_2 || got.variance !== want.variance) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: want est %h %h %h var %h, got est %h %h %h var %h",
                   want.est_0, want.est_1, want.est_2, want.variance,
                   got.est_0, got.est_1, got.est_2, got.variance);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  tskf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  tskf_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic [1:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  fusion_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;

  two_source_kalman_fusion uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: ready decided at falling edge, result taken at rising edge
  always @(negedge clk)
    out_ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);

  // valid drops after each request before the next one is offered
  task automatic send_request(tskf_pkg::in_item_t req);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    @(negedge clk);
    in_valid <= 0;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(32'h3_0000) - 32'h1_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_noise();
    case ($urandom_range(5))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(32'h4_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic make_req(logic [1:0] cmd, logic [31:0] a, logic [31:0] b,
                          logic [31:0] c);
    tskf_pkg::in_item_t req;
    req.command = cmd; req.meas_0 = a; req.meas_1 = b; req.meas_2 = c;
    send_request(req);
  endtask

  task automatic random_phase(int n);
    logic [1:0] cmd;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(19) == 0) ? 2'(CMD_UNUSED) : 2'($urandom_range(2));
      make_req(cmd, rand_word(), rand_word(), rand_word());
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: extremes, every command, zero p+r, variance saturation
    make_req(tskf_pkg::CMD_SRC1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    make_req(tskf_pkg::CMD_SRC2, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
    make_req(tskf_pkg::CMD_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    make_req(2'(CMD_UNUSED), 32'h1234_5678, 0, 0);
    drain();
    write_reg(tskf_pkg::REG_R1, 0);
    write_reg(tskf_pkg::REG_R2, 32'hFFFF_FFFF);
    write_reg(tskf_pkg::REG_Q, 32'hFFFF_FFFF);
    write_reg(2'(REG_BAD), 32'h5555_5555);
    make_req(tskf_pkg::CMD_SRC1, 32'h0002_0000, 32'hFFFE_0000, 32'h7FFF_FFFF);
    // r1 = 0: variance goes to zero, then p+r = 0 on the next update
    make_req(tskf_pkg::CMD_SRC1, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    make_req(tskf_pkg::CMD_PREDICT, 0, 0, 0);
    make_req(tskf_pkg::CMD_PREDICT, 0, 0, 0);
    make_req(tskf_pkg::CMD_SRC2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    write_reg(tskf_pkg::REG_Q, 0);
    write_reg(tskf_pkg::REG_R1, 0);
    make_req(tskf_pkg::CMD_SRC1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    make_req(tskf_pkg::CMD_PREDICT, 0, 0, 0);
    make_req(tskf_pkg::CMD_SRC1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();

    // random phases with varied noise settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin send_idle_pct = 6; recv_idle_pct = 45; end
      else if (ph == 2) begin send_idle_pct = 45; recv_idle_pct = 6; end
      else if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(tskf_pkg::REG_Q, (ph == 5) ? 32'hFFFF_FFFF : rand_noise());
      write_reg(tskf_pkg::REG_R1, (ph == 1) ? 32'h0 : rand_noise());
      write_reg(tskf_pkg::REG_R2, (ph == 3) ? 32'hFFFF_FFFF : rand_noise());
      if (ph == 4) begin
        fork
          begin
            hold_off = 1;
            repeat (1500) @(negedge clk);
            hold_off = 0;
          end
          random_phase(10);
        join
      end
      random_phase(88);
      drain();
    end

    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

// File: files.f
rtl/core/tskf_pkg.sv
rtl/core/tskf_ctrl.sv
rtl/core/tskf_dp.sv
rtl/core/two_source_kalman_fusion.sv
verif/two_source_kalman_fusion_test.sv
